FILE: rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
package lr_pkg;

  localparam int unsigned COORD_BITS = 10;
  localparam int unsigned SPAN_W     = COORD_BITS + 1;
  localparam int unsigned ERR_W      = COORD_BITS + 3;
  localparam int unsigned COLOR_W    = 32;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  localparam logic STEP_UP   = 1'b0;
  localparam logic STEP_DOWN = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic               req_type;
    coord_t             start_x;
    coord_t             start_y;
    coord_t             end_x;
    coord_t             end_y;
    logic [COLOR_W-1:0] line_color;
  } req_t;

  typedef struct packed {
    coord_t             pixel_x;
    coord_t             pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pix_t;

  typedef struct packed {
    logic               steep_flag;
    coord_t             major_pos;
    coord_t             major_end;
    coord_t             minor_pos;
    logic               minor_step;
    logic [SPAN_W-1:0]  major_span;
    logic [SPAN_W-1:0]  minor_span;
    logic [ERR_W-1:0]   error_term;
    logic [COLOR_W-1:0] held_color;
  } line_state_t;

endpackage

FILE: rtl/line_rasterizer.sv
// A request is held in the request register; its pixel then reaches out_valid_o through the pixel register.
// Throughput: one request per cycle while the output is not stalled; each start request
//   and each next request on an active line yields one pixel; the error-term update is combinational.
// A next request while no line is active is dropped without a pixel.
// Reset (rst_ni low, asynchronous) empties both registers and leaves the walker idle.
module line_rasterizer (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  lr_pkg::req_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lr_pkg::pix_t out_data_o
);
  import lr_pkg::*;

  logic  req_vld_q, req_vld_d;
  req_t  req_q;
  logic  out_vld_q, out_vld_d;
  pix_t  out_q;
  pix_t  pix;
  logic  has_result;
  logic  out_free;
  logic  req_leave;
  logic  fire;
  logic  in_xfer;

  lr_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_i        (req_q),
    .has_result_o (has_result),
    .pix_o        (pix)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  // a request without a pixel leaves even when the output is blocked
  assign req_leave  = req_vld_q && (!has_result || out_free);
  assign fire       = req_vld_q && has_result && out_free;
  assign in_stall_o = req_vld_q && !req_leave;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign req_vld_d = in_xfer || (req_vld_q && !req_leave);
  assign out_vld_d = fire || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      req_vld_q <= req_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i;
    end
    if (fire) begin
      out_q <= pix;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/lr_setup.sv
// Line setup: orders the endpoints along the major axis and seeds the error term.
module lr_setup (
  input  lr_pkg::req_t        req_i,
  output lr_pkg::line_state_t init_o
);
  import lr_pkg::*;

  coord_t adx, ady;
  coord_t ma0, mi0, mb0, nb0;
  coord_t ma, mi, mb, nb;
  logic   steep;
  logic   step_dir;
  logic [SPAN_W-1:0] maj_span;

  always_comb begin
    adx = (req_i.start_x > req_i.end_x) ? req_i.start_x - req_i.end_x
                                        : req_i.end_x - req_i.start_x;
    ady = (req_i.start_y > req_i.end_y) ? req_i.start_y - req_i.end_y
                                        : req_i.end_y - req_i.start_y;
    steep = (adx < ady);
    if (steep) begin
      ma0 = req_i.start_y; mi0 = req_i.start_x; mb0 = req_i.end_y; nb0 = req_i.end_x;
    end else begin
      ma0 = req_i.start_x; mi0 = req_i.start_y; mb0 = req_i.end_x; nb0 = req_i.end_y;
    end
    // swap endpoints so the major coordinate rises
    if (ma0 > mb0) begin
      ma = mb0; mb = ma0; mi = nb0; nb = mi0;
    end else begin
      ma = ma0; mb = mb0; mi = mi0; nb = nb0;
    end
    step_dir = (nb < mi) ? STEP_DOWN : STEP_UP;
    maj_span = SPAN_W'(mb - ma);

    init_o.steep_flag = steep;
    init_o.major_pos  = ma;
    init_o.major_end  = mb;
    init_o.minor_pos  = mi;
    init_o.minor_step = step_dir;
    init_o.major_span = maj_span;
    init_o.minor_span = (nb > mi) ? SPAN_W'(nb - mi) : SPAN_W'(mi - nb);
    // hold back at exact halves when walking down
    if (step_dir == STEP_DOWN && maj_span != '0) begin
      init_o.error_term = ERR_W'(maj_span - SPAN_W'(1));
    end else begin
      init_o.error_term = ERR_W'(maj_span);
    end
    init_o.held_color = req_i.line_color;
  end

endmodule

FILE: rtl/lr_walk.sv
// Line walker: holds the line state, steps the error term and forms each pixel.
module lr_walk (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  lr_pkg::req_t req_i,
  output logic         has_result_o,
  output lr_pkg::pix_t pix_o
);
  import lr_pkg::*;

  line_state_t       st_q, st_d, init, stepped;
  logic              active_q, active_d;
  logic [ERR_W-1:0]  err_sum, twice_major;
  logic              last;
  logic              is_start;

  lr_setup u_setup (
    .req_i  (req_i),
    .init_o (init)
  );

  assign is_start     = (req_i.req_type == REQ_START);
  assign has_result_o = is_start || active_q;

  always_comb begin
    stepped     = st_q;
    err_sum     = st_q.error_term + ERR_W'({st_q.minor_span, 1'b0});
    twice_major = ERR_W'({st_q.major_span, 1'b0});
    stepped.major_pos  = st_q.major_pos + coord_t'(1);
    stepped.error_term = err_sum;
    if (err_sum >= twice_major && st_q.minor_span != '0) begin
      stepped.error_term = err_sum - twice_major;
      if (st_q.minor_step == STEP_DOWN) begin
        stepped.minor_pos = st_q.minor_pos - coord_t'(1);
      end else begin
        stepped.minor_pos = st_q.minor_pos + coord_t'(1);
      end
    end

    st_d = is_start ? init : stepped;
    last = (st_d.major_pos == st_d.major_end);
    active_d = !last;

    pix_o.pixel_x     = st_d.steep_flag ? st_d.minor_pos : st_d.major_pos;
    pix_o.pixel_y     = st_d.steep_flag ? st_d.major_pos : st_d.minor_pos;
    pix_o.pixel_color = st_d.held_color;
    pix_o.last_pixel  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      st_q     <= '0;
    end else if (fire_i) begin
      active_q <= active_d;
      st_q     <= st_d;
    end
  end

endmodule

FILE: rtl/lr_checker.sv
// Port-level checks for the line rasterizer, bound to the top level.
module lr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_stall_o,
  input lr_pkg::req_t in_data_i,
  input logic         out_valid_o,
  input logic         out_stall_i,
  input lr_pkg::pix_t out_data_o
);
  import lr_pkg::*;

  // input is held back only by a blocked pixel
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output not blocked");

  // a start transfer yields a pixel if the output is free as soon as the request is registered
  a_start_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.req_type == REQ_START)
      ##1 (!out_valid_o || !out_stall_i) |=> out_valid_o)
    else $error("start transfer produced no pixel");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled pixel changed");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("pixel valid right after reset");

endmodule

bind line_rasterizer lr_checker u_lr_checker (.*);
